### rtl/adf_pkg.sv
// Package for the API frame deframer: frame constants, sequencer states and
// the structures passed between the core and its output buffer.
// Used by adf_out_buf, the core and the testbench; depends on nothing.
package adf_pkg;

  localparam int unsigned FRAME_CAP_DEF = 64;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HDR_W  = 2;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned PAY_W  = 17;

  localparam logic [BYTE_W-1:0] DELIM     = 8'h7E;
  localparam logic [HDR_W-1:0]  HDR_START = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_PUT2,
    ST_BURST
  } state_e;

  // One output byte together with its frame markers.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_of_frame;
    logic              overflow_flush;
  } beat_t;

  // Occupancy of the output buffer, seen by the read issue logic.
  typedef struct packed {
    logic [1:0] held;
    logic       pop;
  } buf_stat_t;

endpackage

### rtl/adf_in_if.sv
// Input channel of the API frame deframer: one received serial byte per
// transaction. Depends on nothing.
interface adf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       command_mode;

  modport source (output valid, rx_byte, command_mode, input ready);
  modport sink   (input valid, rx_byte, command_mode, output ready);
endinterface

### rtl/adf_out_if.sv
// Output channel of the API frame deframer: one stored frame byte per
// transaction. Depends on nothing.
interface adf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_of_frame;
  logic       overflow_flush;

  modport source (output valid, data_byte, last_of_frame, overflow_flush, input ready);
  modport sink   (input valid, data_byte, last_of_frame, overflow_flush, output ready);
endinterface

### rtl/adf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module adf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/adf_out_buf.sv
// Two-entry output buffer: holds bytes read from the frame store until the
// sink takes them. Depends on adf_pkg and adf_out_if.
module adf_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  adf_pkg::beat_t      beat_i,
  output adf_pkg::buf_stat_t  stat_o,
  adf_out_if.source           frm_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  adf_pkg::beat_t out_q, out_d;
  adf_pkg::beat_t skid_q, skid_d;
  logic           pop;

  assign pop = out_valid_q & frm_o.ready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = push_i;
        skid_d       = beat_i;
      end else begin
        out_valid_d = push_i;
        out_d       = beat_i;
      end
    end else if (!out_valid_q) begin
      out_valid_d = push_i;
      out_d       = beat_i;
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign stat_o.held = {1'b0, out_valid_q} + {1'b0, skid_valid_q};
  assign stat_o.pop  = pop;

  assign frm_o.valid          = out_valid_q;
  assign frm_o.data_byte      = out_q.data_byte;
  assign frm_o.last_of_frame  = out_q.last_of_frame;
  assign frm_o.overflow_flush = out_q.overflow_flush;

  // A byte must never arrive while both entries are held and none leaves.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !frm_o.ready) |-> !skid_valid_q)
    else $error("output buffer overrun");

endmodule

### rtl/api_frame_deframer_core.sv
// Top level of the API frame deframer: header/payload tracking, the frame
// store and the burst read-out. Depends on adf_pkg, adf_in_if, adf_out_if,
// adf_ram and adf_out_buf.
//
//  channel | dir | transaction        | payload
//  rx_i    | in  | one serial byte    | rx_byte, command_mode
//  frm_o   | out | one frame byte     | data_byte, last_of_frame, overflow_flush
//
// A byte is accepted in ST_IDLE and applied in ST_STEP, followed by ST_PUT2 when
// it is a delimiter that starts a header, and dropped on acceptance in command
// mode; a finished or overflowing frame is read out in ST_BURST. The burst rate
// is set by the single RAM read port, one byte per cycle while the sink keeps up.
// Reset clears all counters; the frame store itself is not cleared.
// A stalled sink holds the burst through a two-entry output buffer; rx_i is
// ready only while the sequencer is idle.
module api_frame_deframer_core #(
  parameter int unsigned FRAME_CAP = adf_pkg::FRAME_CAP_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  adf_in_if.sink    rx_i,
  adf_out_if.source frm_o
);

  localparam int unsigned CW = $clog2(FRAME_CAP + 1);
  localparam int unsigned AW = $clog2(FRAME_CAP);

  adf_pkg::state_e state_q, state_d;

  logic [CW-1:0]               count_q, count_d;
  logic [adf_pkg::HDR_W-1:0]   hdr_q, hdr_d;
  logic [adf_pkg::PAY_W-1:0]   pay_q, pay_d;
  logic [adf_pkg::LEN_W-1:0]   len_q, len_d;
  logic [adf_pkg::BYTE_W-1:0]  byte_q, byte_d;
  logic                        cmd_q, cmd_d;
  logic                        ovf_q, ovf_d;
  logic [CW-1:0]               n_q, n_d;
  logic [CW-1:0]               rd_q, rd_d;
  logic                        rd_valid_q, rd_valid_d;
  logic                        rd_last_q, rd_last_d;
  logic                        rd_ovf_q, rd_ovf_d;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic                        re;
  logic [adf_pkg::BYTE_W-1:0]  rdata;

  adf_pkg::buf_stat_t          stat;
  adf_pkg::beat_t              beat;
  logic [1:0]                  occ;
  logic                        issue_ok;
  logic                        accept;

  // Update decode for one byte.
  logic                        hdr_take, pay_take, put1, put2, done;
  logic [adf_pkg::HDR_W-1:0]   hdr_a, hdr_b;
  logic [adf_pkg::LEN_W-1:0]   len_a;
  logic [adf_pkg::PAY_W-1:0]   pay_a, pay_b;

  assign rx_i.ready = (state_q == adf_pkg::ST_IDLE);
  assign accept     = rx_i.valid & rx_i.ready;

  // Bytes held in the output buffer plus the read that is in flight.
  assign occ      = stat.held + {1'b0, rd_valid_q};
  assign issue_ok = (occ < 2'd2) || stat.pop;

  always_comb begin
    hdr_take = hdr_q > adf_pkg::HDR_W'(1);
    pay_take = pay_q > adf_pkg::PAY_W'(1);
    put1     = hdr_take | pay_take;
    hdr_a    = hdr_take ? hdr_q - adf_pkg::HDR_W'(1) : hdr_q;
    len_a    = hdr_take ? {len_q[adf_pkg::LEN_W-adf_pkg::BYTE_W-1:0], byte_q} : len_q;
    pay_a    = pay_take ? pay_q - adf_pkg::PAY_W'(1) : pay_q;
    done     = pay_a == adf_pkg::PAY_W'(1);
    // The second length byte completes the header at once.
    if (hdr_a == adf_pkg::HDR_W'(1)) begin
      hdr_b = '0;
      pay_b = {1'b0, len_a} + adf_pkg::PAY_W'(2);
    end else begin
      hdr_b = hdr_a;
      pay_b = pay_a;
    end
    put2 = (byte_q == adf_pkg::DELIM) && (pay_b == '0);
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    hdr_d      = hdr_q;
    pay_d      = pay_q;
    len_d      = len_q;
    byte_d     = byte_q;
    cmd_d      = cmd_q;
    ovf_d      = ovf_q;
    n_d        = n_q;
    rd_d       = rd_q;
    rd_valid_d = 1'b0;
    rd_last_d  = rd_last_q;
    rd_ovf_d   = rd_ovf_q;
    we         = 1'b0;
    waddr      = count_q[AW-1:0];
    re         = 1'b0;

    case (state_q)
      adf_pkg::ST_IDLE: begin
        if (accept) begin
          byte_d = rx_i.rx_byte;
          cmd_d  = rx_i.command_mode;
          if (count_q >= CW'(FRAME_CAP - 1)) begin
            // Store holding FRAME_CAP - 1 bytes or more: flush it before the byte is looked at.
            n_d     = count_q;
            count_d = '0;
            pay_d   = '0;
            ovf_d   = 1'b1;
            rd_d    = '0;
            state_d = adf_pkg::ST_BURST;
          end else if (!rx_i.command_mode) begin
            state_d = adf_pkg::ST_STEP;
          end
        end
      end

      adf_pkg::ST_STEP: begin
        we    = put1;
        len_d = len_a;
        if (done) begin
          n_d     = count_q + CW'(1);
          count_d = '0;
          pay_d   = '0;
          ovf_d   = 1'b0;
          rd_d    = '0;
          state_d = adf_pkg::ST_BURST;
        end else begin
          count_d = count_q + CW'(put1);
          pay_d   = pay_b;
          if (put2) begin
            hdr_d   = adf_pkg::HDR_START;
            state_d = adf_pkg::ST_PUT2;
          end else begin
            hdr_d   = hdr_b;
            state_d = adf_pkg::ST_IDLE;
          end
        end
      end

      adf_pkg::ST_PUT2: begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
        state_d = adf_pkg::ST_IDLE;
      end

      adf_pkg::ST_BURST: begin
        if (issue_ok) begin
          re         = 1'b1;
          rd_valid_d = 1'b1;
          rd_last_d  = rd_q == n_q - CW'(1);
          rd_ovf_d   = ovf_q;
          rd_d       = rd_q + CW'(1);
          if (rd_q == n_q - CW'(1)) begin
            state_d = (ovf_q && !cmd_q) ? adf_pkg::ST_STEP : adf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = adf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= adf_pkg::ST_IDLE;
      count_q    <= '0;
      hdr_q      <= '0;
      pay_q      <= '0;
      len_q      <= '0;
      cmd_q      <= 1'b0;
      ovf_q      <= 1'b0;
      n_q        <= '0;
      rd_q       <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      hdr_q      <= hdr_d;
      pay_q      <= pay_d;
      len_q      <= len_d;
      cmd_q      <= cmd_d;
      ovf_q      <= ovf_d;
      n_q        <= n_d;
      rd_q       <= rd_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    rd_last_q <= rd_last_d;
    rd_ovf_q  <= rd_ovf_d;
  end

  adf_ram #(
    .WIDTH (adf_pkg::BYTE_W),
    .DEPTH (FRAME_CAP)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .re_i    (re),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign beat.data_byte      = rdata;
  assign beat.last_of_frame  = rd_last_q;
  assign beat.overflow_flush = rd_ovf_q;

  adf_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rd_valid_q),
    .beat_i (beat),
    .stat_o (stat),
    .frm_o  (frm_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FRAME_CAP))
    else $error("frame store count beyond capacity");

  a_hdr_pay_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q > adf_pkg::HDR_W'(1)) |-> (pay_q == '0))
    else $error("header and payload collection overlap");

  a_burst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == adf_pkg::ST_BURST) |-> (rd_q < n_q))
    else $error("burst read beyond stored bytes");

  a_no_write_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> !we)
    else $error("store written during a burst read");

endmodule

### verif/tb_api_frame_deframer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for api_frame_deframer_core: serial bytes go in, and every
// frame byte that comes out is checked against a frame rebuilder kept in the testbench.
// Depends on adf_pkg, adf_in_if, adf_out_if and the RTL of the block.
module tb_api_frame_deframer_core;

  localparam int unsigned FRAME_CAP    = adf_pkg::FRAME_CAP_DEF;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum logic [1:0] {
    RDY_FULL,
    RDY_COIN,
    RDY_SPARSE,
    RDY_HOLD
  } rdy_mode_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       command_mode;
    logic       drain_first;
  } rx_item_t;

  logic clk_i;
  logic rst_ni;

  adf_in_if  rx_if ();
  adf_out_if frm_if ();

  api_frame_deframer_core #(
    .FRAME_CAP(FRAME_CAP)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .frm_o (frm_if)
  );

  // Bytes waiting to be offered, and frame bytes the block still owes us.
  rx_item_t       pending_rx[$];
  adf_pkg::beat_t frame_beats_due[$];

  // Shadow of the block's frame state.
  logic [7:0]  shadow_store [FRAME_CAP];
  logic [6:0]  held_cnt;
  logic [1:0]  hdr_left;
  logic [16:0] pay_left;
  logic [15:0] len_hold;

  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned rdy_left;
  rdy_mode_e   rdy_mode;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  always #5 clk_i = ~clk_i;

  task automatic store_byte(input logic [7:0] b);
    if (held_cnt < FRAME_CAP) begin
      shadow_store[held_cnt] = b;
      held_cnt++;
    end
  endtask

  task automatic flush_store(input logic ovf);
    adf_pkg::beat_t beat;
    for (int unsigned k = 0; k < held_cnt; k++) begin
      beat.data_byte      = shadow_store[k];
      beat.last_of_frame  = (k + 1 == held_cnt);
      beat.overflow_flush = ovf;
      frame_beats_due.push_back(beat);
    end
    held_cnt = '0;
  endtask

  // Applies one accepted serial byte to the shadow state and queues the frame
  // bytes it releases.
  task automatic absorb_byte(input logic [7:0] b, input logic cmd);
    if (held_cnt >= FRAME_CAP - 1) begin
      flush_store(1'b1);
      pay_left = '0;
    end
    if (cmd) return;
    if (hdr_left > 1) begin
      hdr_left--;
      len_hold = {len_hold[7:0], b};
      store_byte(b);
    end
    if (pay_left > 1) begin
      pay_left--;
      store_byte(b);
    end
    if (pay_left == 1) begin
      pay_left = '0;
      flush_store(1'b0);
      return;
    end
    if (hdr_left == 1) begin
      pay_left = {1'b0, len_hold} + 17'd2;
      hdr_left = '0;
    end
    if (b == adf_pkg::DELIM && pay_left == 0) begin
      hdr_left = adf_pkg::HDR_START;
      store_byte(b);
    end
  endtask

  task automatic push_rx(input logic [7:0] b, input logic cmd, input logic drain);
    pending_rx.push_back('{rx_byte: b, command_mode: cmd, drain_first: drain});
  endtask

  // A delimiter, the two length bytes, then body_n payload and checksum bytes,
  // with the odd command mode byte slipped in between.
  task automatic push_frame(input logic [15:0] len, input int unsigned body_n,
                            input logic drain);
    push_rx(adf_pkg::DELIM, 1'b0, drain);
    push_rx(len[15:8], 1'b0, 1'b0);
    push_rx(len[7:0], 1'b0, 1'b0);
    for (int unsigned k = 0; k < body_n; k++) begin
      if ($urandom_range(0, 9) == 0) push_rx(8'($urandom), 1'b1, 1'b0);
      push_rx(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  // Sender: offers the head of the queue unless a gap is running or the head
  // must wait for every outstanding frame byte.
  always @(negedge clk_i) begin
    if (!rst_ni || gap_left != 0 || pending_rx.size() == 0) begin
      rx_if.valid <= 1'b0;
    end else if (pending_rx[0].drain_first && frame_beats_due.size() != 0) begin
      rx_if.valid <= 1'b0;
    end else begin
      rx_if.valid        <= 1'b1;
      rx_if.rx_byte      <= pending_rx[0].rx_byte;
      rx_if.command_mode <= pending_rx[0].command_mode;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) begin
        absorb_byte(rx_if.rx_byte, rx_if.command_mode);
        void'(pending_rx.pop_front());
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            4, 5, 6, 7: gap_left = $urandom_range(1, 8);
            default:    gap_left = $urandom_range(20, 80);
          endcase
        end else begin
          burst_left--;
        end
      end else if (gap_left != 0) begin
        gap_left--;
      end
    end
  end

  // Receiver: ready follows a mode that is drawn anew when its random run ends.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      frm_if.ready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode = rdy_mode_e'($urandom_range(0, 3));
        rdy_left = $urandom_range(5, 60);
      end
      rdy_left--;
      case (rdy_mode)
        RDY_FULL:   frm_if.ready <= 1'b1;
        RDY_COIN:   frm_if.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: frm_if.ready <= ($urandom_range(0, 3) == 0);
        default:    frm_if.ready <= (rdy_left % 17 == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    adf_pkg::beat_t due;
    if (rst_ni && frm_if.valid && frm_if.ready) begin
      if (frame_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: unexpected frame byte %02h last %0b overflow %0b",
                   cycle_cnt, frm_if.data_byte, frm_if.last_of_frame,
                   frm_if.overflow_flush);
      end else begin
        due = frame_beats_due.pop_front();
        if (frm_if.data_byte !== due.data_byte
            || frm_if.last_of_frame !== due.last_of_frame
            || frm_if.overflow_flush !== due.overflow_flush) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: expected byte %02h last %0b overflow %0b, got %02h %0b %0b",
                     cycle_cnt, due.data_byte, due.last_of_frame, due.overflow_flush,
                     frm_if.data_byte, frm_if.last_of_frame, frm_if.overflow_flush);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("** api_frame_deframer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned counted;
    int unsigned n;
    logic [15:0] len;
    bit          first_long;

    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    rx_if.valid        = 1'b0;
    rx_if.rx_byte      = '0;
    rx_if.command_mode = 1'b0;
    frm_if.ready       = 1'b0;
    held_cnt           = '0;
    hdr_left           = '0;
    pay_left           = '0;
    len_hold           = '0;
    gap_left           = 0;
    burst_left         = 1;
    rdy_left           = 0;
    rdy_mode           = RDY_FULL;
    mismatches         = 0;
    cycle_cnt          = 0;
    counted            = 0;
    first_long         = 1'b1;

    // Directed part. Bytes outside a frame are ignored, also in command mode.
    push_rx(8'h00, 1'b0, 1'b0);
    push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(adf_pkg::DELIM, 1'b1, 1'b0);
    // Empty payload: delimiter, zero length and checksum only.
    push_rx(adf_pkg::DELIM, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0);
    push_rx(8'hA5, 1'b0, 1'b0);
    // A delimiter inside the payload is plain data.
    push_rx(adf_pkg::DELIM, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0);
    push_rx(8'h02, 1'b0, 1'b0);
    push_rx(adf_pkg::DELIM, 1'b0, 1'b0);
    push_rx(8'hFF, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0);
    // A delimiter as length MSB restarts the header and is stored twice;
    // a command mode byte inside the payload is dropped.
    push_rx(adf_pkg::DELIM, 1'b0, 1'b0);
    push_rx(adf_pkg::DELIM, 1'b0, 1'b0);
    push_rx(8'h00, 1'b0, 1'b0);
    push_rx(8'h01, 1'b0, 1'b0);
    push_rx(8'h55, 1'b0, 1'b0);
    push_rx(8'h7E, 1'b1, 1'b0);
    push_rx(8'hAA, 1'b0, 1'b0);
    push_rx(8'hFF, 1'b1, 1'b0);

    // Random part: mostly well-formed frames, plus long frames that fill the
    // store, stray bytes, cut-off headers and runs of delimiters.
    while (counted < 150) begin
      case ($urandom_range(0, 99)) inside
        [0:59]: begin
          len = 16'($urandom_range(0, 12));
          push_frame(len, len + 1, counted == 0 || $urandom_range(0, 19) == 0);
          counted += len + 4;
        end
        [60:71]: begin
          if (first_long) begin
            len = 16'hFFFF;
          end else begin
            case ($urandom_range(0, 2))
              0:       len = 16'($urandom_range(56, 64));
              1:       len = 16'($urandom_range(65, 16'hFFFF));
              default: len = 16'($urandom);
            endcase
          end
          first_long = 1'b0;
          n = (int'(len) + 1 < 70) ? int'(len) + 1 : 70;
          push_frame(len, n, counted == 0);
          counted += n + 3;
        end
        [72:84]: begin
          n = $urandom_range(1, 6);
          for (int unsigned k = 0; k < n; k++)
            push_rx(8'($urandom), $urandom_range(0, 7) == 0, counted == 0 && k == 0);
          counted += n;
        end
        [85:92]: begin
          n = $urandom_range(0, 1);
          push_rx(adf_pkg::DELIM, 1'b0, counted == 0);
          for (int unsigned k = 0; k < n; k++) push_rx(8'($urandom), 1'b0, 1'b0);
          counted += n + 1;
        end
        default: begin
          // Each delimiter after the first is stored twice, so a long run
          // overflows the store while still in the header.
          n = $urandom_range(2, 40);
          for (int unsigned k = 0; k < n; k++)
            push_rx(adf_pkg::DELIM, 1'b0, counted == 0 && k == 0);
          counted += n;
        end
      endcase
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_rx.size() != 0 || frame_beats_due.size() != 0) @(negedge clk_i);
    repeat (FRAME_CAP + 8) @(negedge clk_i);

    if (mismatches == 0 && frame_beats_due.size() == 0) begin
      $display("** api_frame_deframer_core: PASSED **");
    end else begin
      $display("** api_frame_deframer_core: FAILED **");
    end
    $finish;
  end

endmodule
